// File: design/frr_pkg.sv
`timescale 1ns / 1ps
// frr_pkg: shared types and codes of the frame router with route learning
// no dependencies

package frr_pkg;

  typedef enum logic [1:0] {
    OP_INCOMING = 2'd0,
    OP_SEND     = 2'd1,
    OP_ADD      = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ACT_LOCAL = 3'd0,
    ACT_FWD   = 3'd1,
    ACT_DROP  = 3'd2,
    ACT_ADDED = 3'd3,
    ACT_FULL  = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_SRC,
    ST_LEARN,
    ST_SCAN_DST,
    ST_ADD
  } state_t;

  typedef enum logic {
    REG_OWN   = 1'b0,
    REG_BCAST = 1'b1
  } reg_idx_t;

  localparam logic [7:0] HOST_MASK  = 8'hFF;
  localparam logic [7:0] BCAST_INIT = 8'hFF;

  typedef struct packed {
    logic [7:0] dest;
    logic [7:0] mask;
    logic [3:0] ifc;
    logic [7:0] hop;
  } route_entry_t;

  typedef struct packed {
    action_t    action;
    logic [3:0] ifc;
    logic [7:0] via;
    logic [7:0] src;
    logic [2:0] prio;
    logic [4:0] proto;
    logic [7:0] ctl;
    logic       learned;
  } result_t;

endpackage

// File: design/frame_router_with_route_learning_top.sv
`timescale 1ns / 1ps
// frame_router_with_route_learning_top: register port, sequencer, table and compare
// depends on frr_pkg, frr_table, frr_match, frr_ctrl

// Routing table with source learning, searched first-match in insertion order.
// Command channel: a beat is taken when start is high and busy is low; the
// in_ ports are sampled at that edge. Operation 3 is ignored and gives no beat.
// Result channel: out_valid is high for one cycle with the out_ fields; the
// receiver takes every beat and cannot stall the block.
// Add route writes unless the table is full; local send scans the destination;
// incoming header: as needed, source scan, host route insert and destination
// scan. Each scan reads one table entry per cycle through the single memory
// read port and the one masked compare unit; busy stays high meanwhile.
// The next command may be given in the cycle that out_valid is shown.
// Registers on the APB port: own address at 0x0, broadcast address at 0x4.
// Reset (rst_n low at a clock edge) empties the table, sets own address to 0
// and broadcast to 0xff; table contents are not cleared, only the count.

module frame_router_with_route_learning_top import frr_pkg::*; #(
  parameter int ROUTE_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_dest_addr,
  input  logic [7:0]  in_src_addr,
  input  logic [7:0]  in_header_ctl,
  input  logic [2:0]  in_prio,
  input  logic [4:0]  in_protocol,
  input  logic [7:0]  in_dest_mask,
  input  logic [3:0]  in_interface_idx,
  input  logic [7:0]  in_link_addr,
  output logic        out_valid,
  output logic [2:0]  out_action,
  output logic [3:0]  out_out_interface,
  output logic [7:0]  out_via_addr,
  output logic [7:0]  out_src_addr_out,
  output logic [2:0]  out_prio_out,
  output logic [4:0]  out_protocol_out,
  output logic [7:0]  out_header_ctl_out,
  output logic        out_learned
);

  localparam int CNT_W = $clog2(ROUTE_SLOTS);

  logic [7:0] own_r, bcast_r;
  logic       cfg_wr;
  reg_idx_t   cfg_sel;

  logic             wr_en;
  logic [CNT_W-1:0] wr_addr, rd_addr;
  route_entry_t     wr_data, rd_data;
  logic [7:0]       key;
  logic             match_hit;
  logic             res_valid;
  result_t          res;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r   <= 8'h00;
      bcast_r <= BCAST_INIT;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_OWN:   own_r   <= pwdata[7:0];
        REG_BCAST: bcast_r <= pwdata[7:0];
        default:   own_r   <= own_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_OWN:   prdata = {24'h000000, own_r};
      REG_BCAST: prdata = {24'h000000, bcast_r};
      default:   prdata = 32'h00000000;
    endcase
  end

  frr_table #(.ROUTE_SLOTS(ROUTE_SLOTS)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  frr_match u_match (
    .key   (key),
    .entry (rd_data),
    .hit   (match_hit)
  );

  frr_ctrl #(.ROUTE_SLOTS(ROUTE_SLOTS)) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_dest_addr     (in_dest_addr),
    .in_src_addr      (in_src_addr),
    .in_header_ctl    (in_header_ctl),
    .in_prio          (in_prio),
    .in_protocol      (in_protocol),
    .in_dest_mask     (in_dest_mask),
    .in_interface_idx (in_interface_idx),
    .in_link_addr     (in_link_addr),
    .node_addr        (own_r),
    .bcast_addr       (bcast_r),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .key              (key),
    .match_hit        (match_hit),
    .res_valid        (res_valid),
    .res              (res)
  );

  assign out_valid          = res_valid;
  assign out_action         = res.action;
  assign out_out_interface  = res.ifc;
  assign out_via_addr       = res.via;
  assign out_src_addr_out   = res.src;
  assign out_prio_out       = res.prio;
  assign out_protocol_out   = res.proto;
  assign out_header_ctl_out = res.ctl;
  assign out_learned        = res.learned;

endmodule

// File: design/frr_table.sv
`timescale 1ns / 1ps
// frr_table: route table memory, one write port and one registered read port
// depends on frr_pkg

module frr_table import frr_pkg::*; #(
  parameter int ROUTE_SLOTS = 16
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(ROUTE_SLOTS)-1:0] wr_addr,
  input  route_entry_t                   wr_data,
  input  logic [$clog2(ROUTE_SLOTS)-1:0] rd_addr,
  output route_entry_t                   rd_data
);

  route_entry_t mem [ROUTE_SLOTS];
  route_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/frr_match.sv
`timescale 1ns / 1ps
// frr_match: masked address compare shared by every table scan
// depends on frr_pkg

module frr_match import frr_pkg::*; (
  input  logic [7:0]   key,
  input  route_entry_t entry,
  output logic         hit
);

  assign hit = ((entry.dest ^ key) & entry.mask) == 8'h00;

endmodule

// File: design/frr_ctrl.sv
`timescale 1ns / 1ps
// frr_ctrl: sequencer for learning, table scans, route insert and result beat
// depends on frr_pkg; drives frr_table and frr_match

module frr_ctrl import frr_pkg::*; #(
  parameter int ROUTE_SLOTS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_operation,
  input  logic [7:0]                     in_dest_addr,
  input  logic [7:0]                     in_src_addr,
  input  logic [7:0]                     in_header_ctl,
  input  logic [2:0]                     in_prio,
  input  logic [4:0]                     in_protocol,
  input  logic [7:0]                     in_dest_mask,
  input  logic [3:0]                     in_interface_idx,
  input  logic [7:0]                     in_link_addr,
  input  logic [7:0]                     node_addr,
  input  logic [7:0]                     bcast_addr,
  output logic                           wr_en,
  output logic [$clog2(ROUTE_SLOTS)-1:0] wr_addr,
  output route_entry_t                   wr_data,
  output logic [$clog2(ROUTE_SLOTS)-1:0] rd_addr,
  input  route_entry_t                   rd_data,
  output logic [7:0]                     key,
  input  logic                           match_hit,
  output logic                           res_valid,
  output result_t                        res
);

  localparam int CNT_W = $clog2(ROUTE_SLOTS);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(ROUTE_SLOTS - 1);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r, idx_r;
  logic             pend_r;
  logic             learned_r;
  logic             res_valid_r;
  result_t          res_r, res_nxt;

  op_t        op_r;
  logic [7:0] dst_r, src_r, ctl_r, mask_r, lla_r;
  logic [2:0] prio_r;
  logic [4:0] proto_r;
  logic [3:0] ifc_r;

  logic acc, hit, more, full, is_local, in_scan, issue, fin;

  assign acc      = start && (state_r == ST_IDLE);
  assign hit      = pend_r && match_hit;
  assign more     = idx_r < count_r;
  assign full     = count_r == CAP;
  assign is_local = (dst_r == node_addr) || (dst_r == bcast_addr);
  assign in_scan  = (state_r == ST_SCAN_SRC) || (state_r == ST_SCAN_DST);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (op_t'(in_operation))
            OP_INCOMING: state_nxt = ST_SCAN_SRC;
            OP_SEND:     state_nxt = ST_SCAN_DST;
            OP_ADD:      state_nxt = ST_ADD;
            OP_NONE:     state_nxt = ST_IDLE;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN_SRC: begin
        if (hit || !more) begin
          priority if (!hit && !full) state_nxt = ST_LEARN;
          else if (is_local)          state_nxt = ST_IDLE;
          else                        state_nxt = ST_SCAN_DST;
        end
      end
      ST_LEARN: begin
        state_nxt = is_local ? ST_IDLE : ST_SCAN_DST;
      end
      ST_SCAN_DST: begin
        if (hit || !more) state_nxt = ST_IDLE;
      end
      ST_ADD: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    issue   = in_scan && !hit && more;
    fin     = (state_r != ST_IDLE) && (state_nxt == ST_IDLE);
    key     = (state_r == ST_SCAN_SRC) ? src_r : dst_r;
    rd_addr = idx_r;
    wr_addr = count_r;
    wr_en   = (state_r == ST_LEARN) || ((state_r == ST_ADD) && !full);
    if (state_r == ST_LEARN) begin
      wr_data = '{dest: src_r, mask: HOST_MASK, ifc: ifc_r, hop: lla_r};
    end else begin
      wr_data = '{dest: dst_r, mask: mask_r, ifc: ifc_r, hop: lla_r};
    end

    res_nxt        = '0;
    res_nxt.action = ACT_DROP;
    unique case (op_r)
      OP_INCOMING: res_nxt.prio = ctl_r[7:5];
      OP_SEND:     res_nxt.prio = prio_r;
      default:     res_nxt.prio = 3'd0;
    endcase
    priority if (op_r == OP_ADD) begin
      res_nxt.action = full ? ACT_FULL : ACT_ADDED;
    end else if ((op_r == OP_INCOMING) && is_local) begin
      res_nxt.action = ACT_LOCAL;
      res_nxt.ifc    = ifc_r;
      res_nxt.src    = src_r;
      res_nxt.proto  = ctl_r[4:0];
    end else if (hit) begin
      res_nxt.action = ACT_FWD;
      res_nxt.ifc    = rd_data.ifc;
      res_nxt.via    = rd_data.hop;
    end else begin
      res_nxt.action = ACT_DROP;
    end
    if (op_r == OP_SEND) res_nxt.ctl = {prio_r, proto_r};
    res_nxt.learned = learned_r || (state_r == ST_LEARN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      learned_r   <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= fin;
      if (wr_en) count_r <= count_r + CNT_W'(1);
      if (state_nxt != state_r) begin
        idx_r  <= '0;
        pend_r <= 1'b0;
      end else begin
        pend_r <= issue;
        if (issue) idx_r <= idx_r + CNT_W'(1);
      end
      if (acc) begin
        learned_r <= 1'b0;
      end else if (state_r == ST_LEARN) begin
        learned_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op_r    <= op_t'(in_operation);
      dst_r   <= in_dest_addr;
      src_r   <= in_src_addr;
      ctl_r   <= in_header_ctl;
      prio_r  <= in_prio;
      proto_r <= in_protocol;
      mask_r  <= in_dest_mask;
      ifc_r   <= in_interface_idx;
      lla_r   <= in_link_addr;
    end
    if (fin) res_r <= res_nxt;
  end

  assign busy      = state_r != ST_IDLE;
  assign res_valid = res_valid_r;
  assign res       = res_r;

`ifndef ASSERT_OFF
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP) else $error("route count above capacity");

  a_learn_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LEARN) |-> (count_r != CAP)) else $error("learn with full table");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (count_r == $past(count_r) + CNT_W'(1))) else $error("count not advanced");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_operation != OP_NONE)) |=> busy) else $error("accepted beat not started");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_scan |-> (idx_r <= count_r)) else $error("scan index past table end");
`endif

endmodule

// File: tb/sv/tb_frame_router_with_route_learning_top.sv
`timescale 1ns / 1ps
// tb_frame_router_with_route_learning_top: self-checking bench for the frame router
// drives command beats and register writes, predicts each result beat and compares
// depends on frr_pkg and frame_router_with_route_learning_top

module tb_frame_router_with_route_learning_top;
  import frr_pkg::*;

  localparam int ROUTE_CAP        = 15;
  localparam int SETTLE           = 40;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int RANDOM_PER_PHASE = 110;
  localparam int MAX_REPORTS      = 10;

  typedef struct packed {
    op_t        op;
    logic [7:0] dst;
    logic [7:0] src;
    logic [7:0] ctl;
    logic [2:0] prio;
    logic [4:0] proto;
    logic [7:0] msk;
    logic [3:0] ifc;
    logic [7:0] lla;
  } cmd_t;

  typedef struct {
    cmd_t    c;
    bit      typed;
    result_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_operation = '0;
  logic [7:0]  in_dest_addr = '0;
  logic [7:0]  in_src_addr = '0;
  logic [7:0]  in_header_ctl = '0;
  logic [2:0]  in_prio = '0;
  logic [4:0]  in_protocol = '0;
  logic [7:0]  in_dest_mask = '0;
  logic [3:0]  in_interface_idx = '0;
  logic [7:0]  in_link_addr = '0;
  logic        out_valid;
  logic [2:0]  out_action;
  logic [3:0]  out_out_interface;
  logic [7:0]  out_via_addr;
  logic [7:0]  out_src_addr_out;
  logic [2:0]  out_prio_out;
  logic [4:0]  out_protocol_out;
  logic [7:0]  out_header_ctl_out;
  logic        out_learned;

  // predicted routing state and registers
  logic [7:0] rt_dest [ROUTE_CAP];
  logic [7:0] rt_mask [ROUTE_CAP];
  logic [3:0] rt_ifc  [ROUTE_CAP];
  logic [7:0] rt_hop  [ROUTE_CAP];
  int         rt_count = 0;
  logic [7:0] node_addr_q = 8'h00;
  logic [7:0] bcast_addr_q = 8'hFF;

  result_t pending_results[$];
  result_t seen;
  result_t head_result;
  int      errors = 0;
  int      n_issued = 0;
  int      n_ignored = 0;
  int      n_checked = 0;
  int      n_learned = 0;
  int      act_count[5] = '{0, 0, 0, 0, 0};
  int      stall_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  frame_router_with_route_learning_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_dest_addr       (in_dest_addr),
    .in_src_addr        (in_src_addr),
    .in_header_ctl      (in_header_ctl),
    .in_prio            (in_prio),
    .in_protocol        (in_protocol),
    .in_dest_mask       (in_dest_mask),
    .in_interface_idx   (in_interface_idx),
    .in_link_addr       (in_link_addr),
    .out_valid          (out_valid),
    .out_action         (out_action),
    .out_out_interface  (out_out_interface),
    .out_via_addr       (out_via_addr),
    .out_src_addr_out   (out_src_addr_out),
    .out_prio_out       (out_prio_out),
    .out_protocol_out   (out_protocol_out),
    .out_header_ctl_out (out_header_ctl_out),
    .out_learned        (out_learned)
  );

  assign seen = {out_action, out_out_interface, out_via_addr, out_src_addr_out,
                 out_prio_out, out_protocol_out, out_header_ctl_out, out_learned};

  function automatic string res_str(result_t r);
    return $sformatf("act %0d if %h via %h src %h prio %0d proto %h ctl %h lrn %b",
                     r.action, r.ifc, r.via, r.src, r.prio, r.proto, r.ctl, r.learned);
  endfunction

  function automatic void note_error(string msg);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch: %s", msg);
  endfunction

  function automatic cmd_t mk_cmd(op_t op, logic [7:0] dst, src, ctl, logic [2:0] prio,
                                  logic [4:0] proto, logic [7:0] msk, logic [3:0] ifc,
                                  logic [7:0] lla);
    cmd_t c;
    c.op = op;
    c.dst = dst;
    c.src = src;
    c.ctl = ctl;
    c.prio = prio;
    c.proto = proto;
    c.msk = msk;
    c.ifc = ifc;
    c.lla = lla;
    return c;
  endfunction

  function automatic result_t mk_res(action_t a, logic [3:0] ifc, logic [7:0] via, src,
                                     logic [2:0] prio, logic [4:0] proto, logic [7:0] ctl,
                                     logic lrn);
    result_t r;
    r.action = a;
    r.ifc = ifc;
    r.via = via;
    r.src = src;
    r.prio = prio;
    r.proto = proto;
    r.ctl = ctl;
    r.learned = lrn;
    return r;
  endfunction

  // first match in insertion order
  function automatic bit lookup_route(logic [7:0] a, output logic [3:0] ifc,
                                      output logic [7:0] hop);
    ifc = '0;
    hop = '0;
    for (int k = 0; k < rt_count; k++) begin
      if ((rt_dest[k] & rt_mask[k]) == (a & rt_mask[k])) begin
        ifc = rt_ifc[k];
        hop = rt_hop[k];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit store_route(logic [7:0] d, m, logic [3:0] ifc, logic [7:0] hop);
    if (rt_count >= ROUTE_CAP)
      return 1'b0;
    rt_dest[rt_count] = d;
    rt_mask[rt_count] = m;
    rt_ifc[rt_count] = ifc;
    rt_hop[rt_count] = hop;
    rt_count++;
    return 1'b1;
  endfunction

  function automatic bit route_decision(cmd_t c, output result_t r);
    logic [3:0] hit_ifc;
    logic [7:0] hit_hop;
    r = '0;
    case (c.op)
      OP_INCOMING: begin
        if (!lookup_route(c.src, hit_ifc, hit_hop))
          r.learned = store_route(c.src, HOST_MASK, c.ifc, c.lla);
        r.prio = c.ctl[7:5];
        if (c.dst == node_addr_q || c.dst == bcast_addr_q) begin
          r.action = ACT_LOCAL;
          r.ifc = c.ifc;
          r.src = c.src;
          r.proto = c.ctl[4:0];
        end else if (lookup_route(c.dst, hit_ifc, hit_hop)) begin
          r.action = ACT_FWD;
          r.ifc = hit_ifc;
          r.via = hit_hop;
        end else begin
          r.action = ACT_DROP;
        end
      end
      OP_SEND: begin
        r.prio = c.prio;
        r.ctl = {c.prio, c.proto};
        if (lookup_route(c.dst, hit_ifc, hit_hop)) begin
          r.action = ACT_FWD;
          r.ifc = hit_ifc;
          r.via = hit_hop;
        end else begin
          r.action = ACT_DROP;
        end
      end
      OP_ADD: begin
        r.action = store_route(c.dst, c.msk, c.ifc, c.lla) ? ACT_ADDED : ACT_FULL;
      end
      default: begin
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  // addresses lean towards own, broadcast and routed prefixes so lookups hit
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   pick;
    int   k;
    pick = $urandom_range(99);
    if (pick < 45)
      c.op = OP_INCOMING;
    else if (pick < 75)
      c.op = OP_SEND;
    else if (pick < 88)
      c.op = OP_ADD;
    else
      c.op = OP_NONE;
    c.dst = 8'($urandom);
    c.src = 8'($urandom);
    c.ctl = 8'($urandom);
    c.prio = 3'($urandom);
    c.proto = 5'($urandom);
    c.msk = 8'($urandom);
    c.ifc = 4'($urandom);
    c.lla = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 30) begin
      c.dst = node_addr_q;
    end else if (pick < 40) begin
      c.dst = bcast_addr_q;
    end else if (pick < 70 && rt_count > 0) begin
      k = $urandom_range(rt_count - 1);
      c.dst = (rt_dest[k] & rt_mask[k]) | (c.dst & ~rt_mask[k]);
    end
    if ($urandom_range(99) < 40 && rt_count > 0) begin
      k = $urandom_range(rt_count - 1);
      c.src = (rt_dest[k] & rt_mask[k]) | (c.src & ~rt_mask[k]);
    end
    return c;
  endfunction

  task automatic issue(cmd_t c, int idle_pct, bit typed, result_t want);
    result_t r;
    // before each command the sender idles while a draw out of a hundred falls below idle_pct
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= c.op;
    in_dest_addr <= c.dst;
    in_src_addr <= c.src;
    in_header_ctl <= c.ctl;
    in_prio <= c.prio;
    in_protocol <= c.proto;
    in_dest_mask <= c.msk;
    in_interface_idx <= c.ifc;
    in_link_addr <= c.lla;
    do @(posedge clk); while (busy);
    if (route_decision(c, r)) begin
      pending_results.push_back(typed ? want : r);
      n_issued++;
    end else begin
      n_ignored++;
    end
  endtask

  // hold off until every beat is back, then let the design settle with start low
  task automatic settle_all();
    start <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_access(bit wr, reg_idx_t idx, logic [7:0] v, output logic [31:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= {24'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_reg(reg_idx_t idx, logic [7:0] v);
    logic [31:0] rd;
    apb_access(1'b1, idx, v, rd);
    if (idx == REG_OWN)
      node_addr_q = v;
    else
      bcast_addr_q = v;
    @(posedge clk);
    apb_access(1'b0, idx, 8'h00, rd);
    if (rd !== {24'h0, v})
      note_error($sformatf("register %s read %h, expected %h", idx.name(), rd, v));
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        note_error({"result with nothing expected: ", res_str(seen)});
      end else begin
        head_result = pending_results.pop_front();
        if (seen !== head_result)
          note_error({"expected ", res_str(head_result), " got ", res_str(seen)});
      end
      n_checked++;
      if (seen.action <= ACT_FULL)
        act_count[seen.action]++;
      if (seen.learned === 1'b1)
        n_learned++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", stall_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    row_t       rows[$];
    cmd_t       c;
    int         done_here;
    int         idle_of[4];
    logic [7:0] own_of[4];
    logic [7:0] bcast_of[4];
    idle_of = '{0, 71, 0, 13};
    own_of = '{8'h00, 8'hFF, 8'h42, 8'($urandom)};
    bcast_of = '{8'hFF, 8'h00, 8'h42, 8'($urandom)};

    // empty table, default registers
    rows.push_back('{mk_cmd(OP_SEND, 8'h12, 8'h00, 8'h00, 3'd7, 5'd31, 8'h00, 4'd0, 8'h00),
                     1'b1, mk_res(ACT_DROP, 4'd0, 8'h00, 8'h00, 3'd7, 5'd0, 8'hFF, 1'b0)});
    rows.push_back('{mk_cmd(OP_ADD, 8'h10, 8'h00, 8'h00, 3'd0, 5'd0, 8'hF0, 4'd3, 8'h55),
                     1'b1, mk_res(ACT_ADDED, 4'd0, 8'h00, 8'h00, 3'd0, 5'd0, 8'h00, 1'b0)});
    rows.push_back('{mk_cmd(OP_INCOMING, 8'h00, 8'h20, 8'hE5, 3'd0, 5'd0, 8'h00, 4'hF, 8'hAA),
                     1'b1, mk_res(ACT_LOCAL, 4'hF, 8'h00, 8'h20, 3'd7, 5'h05, 8'h00, 1'b1)});
    rows.push_back('{mk_cmd(OP_INCOMING, 8'hFF, 8'h21, 8'h00, 3'd0, 5'd0, 8'h00, 4'h0, 8'h00),
                     1'b1, mk_res(ACT_LOCAL, 4'h0, 8'h00, 8'h21, 3'd0, 5'h00, 8'h00, 1'b1)});
    rows.push_back('{mk_cmd(OP_INCOMING, 8'h1C, 8'h20, 8'h1F, 3'd7, 5'd31, 8'hFF, 4'd2, 8'h01),
                     1'b0, '0});
    // source learned and used for the destination in the same frame
    rows.push_back('{mk_cmd(OP_INCOMING, 8'h99, 8'h99, 8'h40, 3'd0, 5'd0, 8'h00, 4'd9, 8'h77),
                     1'b0, '0});
    rows.push_back('{mk_cmd(OP_SEND, 8'h21, 8'hFF, 8'hFF, 3'd0, 5'd0, 8'hFF, 4'hF, 8'hFF),
                     1'b0, '0});
    rows.push_back('{mk_cmd(OP_NONE, 8'hFF, 8'hFF, 8'hFF, 3'd7, 5'd31, 8'hFF, 4'hF, 8'hFF),
                     1'b0, '0});
    rows.push_back('{mk_cmd(OP_ADD, 8'h40, 8'h00, 8'h00, 3'd0, 5'd0, 8'hC0, 4'd8, 8'h44),
                     1'b1, mk_res(ACT_ADDED, 4'd0, 8'h00, 8'h00, 3'd0, 5'd0, 8'h00, 1'b0)});
    rows.push_back('{mk_cmd(OP_SEND, 8'h7F, 8'h00, 8'h00, 3'd3, 5'h11, 8'h00, 4'd0, 8'h00),
                     1'b0, '0});
    // fill the table with prefixes in the top quarter of the address space
    repeat (ROUTE_CAP - 5) begin
      c = mk_cmd(OP_ADD, 8'hC0 | 8'($urandom_range(63)), 8'($urandom), 8'($urandom),
                 3'($urandom), 5'($urandom), 8'hFF, 4'($urandom), 8'($urandom));
      case ($urandom_range(3))
        0: c.msk = 8'hFF;
        1: c.msk = 8'hFC;
        2: c.msk = 8'hF0;
        default: c.msk = 8'hE0;
      endcase
      rows.push_back('{c, 1'b0, '0});
    end
    rows.push_back('{mk_cmd(OP_ADD, 8'hAB, 8'h00, 8'h00, 3'd0, 5'd0, 8'h00, 4'd0, 8'hFF),
                     1'b1, mk_res(ACT_FULL, 4'd0, 8'h00, 8'h00, 3'd0, 5'd0, 8'h00, 1'b0)});
    // unknown source with the table full: no learning, frame still dropped
    rows.push_back('{mk_cmd(OP_INCOMING, 8'h05, 8'h05, 8'hA0, 3'd0, 5'd0, 8'h00, 4'd1, 8'h02),
                     1'b1, mk_res(ACT_DROP, 4'd0, 8'h00, 8'h00, 3'd5, 5'd0, 8'h00, 1'b0)});
    rows.push_back('{mk_cmd(OP_SEND, 8'hC3, 8'h00, 8'h00, 3'd1, 5'd1, 8'h00, 4'd0, 8'h00),
                     1'b0, '0});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i])
      issue(rows[i].c, 20, rows[i].typed, rows[i].want);

    for (int phase = 0; phase < 4; phase++) begin
      settle_all();
      set_reg(REG_OWN, own_of[phase]);
      set_reg(REG_BCAST, bcast_of[phase]);
      done_here = 0;
      while (done_here < RANDOM_PER_PHASE) begin
        c = rand_cmd();
        issue(c, idle_of[phase], 1'b0, '0);
        if (c.op != OP_NONE)
          done_here++;
      end
    end
    settle_all();

    $display("ran %0d commands plus %0d ignored ones over 4 register settings",
             n_issued, n_ignored);
    $display("results %0d: local %0d, forward %0d, drop %0d, added %0d, full %0d, learned %0d",
             n_checked, act_count[ACT_LOCAL], act_count[ACT_FWD], act_count[ACT_DROP],
             act_count[ACT_ADDED], act_count[ACT_FULL], n_learned);
    if (errors == 0 && pending_results.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
